// ===== hdl/stc_pkg.sv =====
package stc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned BitCntW = 6;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_CLOCK  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic               edge_fall;
    logic               edge_rise;
    logic               data_level;
    logic [WordW-1:0]   time_us;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0]   capture_id;
    logic [WordW-1:0]   low_duration_us;
    logic [CountW-1:0]  select_falls;
    logic [CountW-1:0]  clock_rises;
    logic [WordW-1:0]   rx_bits;
    logic [BitCntW-1:0] rx_bit_cnt;
  } rec_t;

endpackage

// ===== hdl/stc_if.sv =====
interface stc_req_if;
  logic                     valid;
  logic                     ready;
  stc_pkg::opcode_e         opcode;
  logic                     edge_fall;
  logic                     edge_rise;
  logic                     data_level;
  logic [stc_pkg::WordW-1:0] time_us;

  modport source (
    output valid, opcode, edge_fall, edge_rise, data_level, time_us,
    input  ready
  );
  modport sink (
    input  valid, opcode, edge_fall, edge_rise, data_level, time_us,
    output ready
  );
endinterface

interface stc_rsp_if;
  logic          valid;
  logic          ready;
  logic          record_valid;
  stc_pkg::rec_t rec;
  logic          capture_open;

  modport source (
    output valid, record_valid, rec, capture_open,
    input  ready
  );
  modport sink (
    input  valid, record_valid, rec, capture_open,
    output ready
  );
endinterface

// ===== hdl/stc_capture.sv =====
module stc_capture #(
  parameter int unsigned MAX_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  stc_pkg::req_t req_i,
  output logic          push_o,
  output stc_pkg::rec_t push_rec_o,
  output logic          open_o
);
  import stc_pkg::*;

  localparam int unsigned BitCap = (MAX_BITS < WordW) ? MAX_BITS : WordW;

  logic               open_q,  open_d;
  logic [WordW-1:0]   next_q,  next_d;
  logic [WordW-1:0]   seq_q,   seq_d;
  logic [WordW-1:0]   start_q, start_d;
  logic [CountW-1:0]  falls_q, falls_d;
  logic [CountW-1:0]  rises_q, rises_d;
  logic [WordW-1:0]   bits_q,  bits_d;
  logic [BitCntW-1:0] cnt_q,   cnt_d;
  logic               push;

  always_comb begin
    open_d  = open_q;
    next_d  = next_q;
    seq_d   = seq_q;
    start_d = start_q;
    falls_d = falls_q;
    rises_d = rises_q;
    bits_d  = bits_q;
    cnt_d   = cnt_q;
    push    = 1'b0;
    if (accept_i) begin
      unique case (req_i.opcode)
        OP_SELECT: begin
          if (req_i.edge_fall) begin
            if (!open_d) begin
              seq_d   = next_q;
              next_d  = next_q + WordW'(1);
              start_d = req_i.time_us;
              falls_d = '0;
              rises_d = '0;
              bits_d  = '0;
              cnt_d   = '0;
              open_d  = 1'b1;
            end
            if (falls_d != CountMax) begin
              falls_d = falls_d + CountW'(1);
            end
          end
          if (req_i.edge_rise && open_d) begin
            push   = 1'b1;
            open_d = 1'b0;
          end
        end
        OP_CLOCK: begin
          if (open_q && req_i.edge_rise) begin
            if (cnt_q < BitCntW'(BitCap)) begin
              bits_d = bits_q | (WordW'(req_i.data_level) << cnt_q[4:0]);
              cnt_d  = cnt_q + BitCntW'(1);
            end
            if (rises_q != CountMax) begin
              rises_d = rises_q + CountW'(1);
            end
          end
        end
        OP_READ, OP_NONE: begin
        end
      endcase
    end
  end

  always_comb begin
    push_rec_o.capture_id      = seq_d;
    push_rec_o.low_duration_us = req_i.time_us - start_d;
    push_rec_o.select_falls    = falls_d;
    push_rec_o.clock_rises     = rises_d;
    push_rec_o.rx_bits         = bits_d;
    push_rec_o.rx_bit_cnt      = cnt_d;
  end

  assign push_o = push;
  assign open_o = open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      next_q <= WordW'(1);
    end else begin
      open_q <= open_d;
      next_q <= next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q   <= seq_d;
    start_q <= start_d;
    falls_q <= falls_d;
    rises_q <= rises_d;
    bits_q  <= bits_d;
    cnt_q   <= cnt_d;
  end

  a_close_on_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && req_i.opcode == OP_SELECT && req_i.edge_rise |=> !open_q)
    else $error("capture still open after select rise");

  a_push_only_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (open_q || (req_i.edge_fall && req_i.opcode == OP_SELECT)))
    else $error("record pushed without an open capture");
endmodule

// ===== hdl/stc_ring.sv =====
module stc_ring #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stc_pkg::rec_t push_rec_i,
  input  logic          pop_i,
  output logic          rd_hit_o,
  output stc_pkg::rec_t rd_rec_o
);
  import stc_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(DEPTH);

  rec_t            mem_q [DEPTH];
  rec_t            rd_q;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [OccW-1:0] occ_q,  occ_d;
  logic            full, empty;

  assign full  = (occ_q == FullOcc);
  assign empty = (occ_q == '0);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    hit_d  = hit_q;
    if (push_i) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
      if (full) begin
        tail_d = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
      end else begin
        occ_d = occ_q + OccW'(1);
      end
    end else if (pop_i) begin
      hit_d = !empty;
      if (!empty) begin
        tail_d = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
        occ_d  = occ_q - OccW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
      hit_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[head_q] <= push_rec_i;
    end
    if (pop_i) begin
      rd_q <= mem_q[tail_q];
    end
  end

  assign rd_hit_o = hit_q;
  assign rd_rec_o = rd_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FullOcc)
    else $error("ring occupancy above depth");

  a_full_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full |=> full && $stable(occ_q))
    else $error("ring lost fullness on overwrite");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push_i && empty |=> !hit_q && $stable(tail_q))
    else $error("pop of empty ring moved tail");
endmodule

// ===== hdl/spi_transaction_capture.sv =====
// Read request: the ring entry and open flag are registered in s1, then in the response register.
// Throughput: one request per cycle unless rsp stalls; pin events never produce a response.
// A read holds its registered ring data until the response register frees up, so
// one further request is taken while a response waits.
// Reset (async, active low) closes any capture, empties the ring, restarts ids at 1.
module spi_transaction_capture #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_BITS    = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  stc_req_if.sink          req_i,
  stc_rsp_if.source        rsp_o
);
  import stc_pkg::*;

  req_t req;
  logic accept;
  logic read_acc;
  logic push;
  rec_t push_rec;
  logic open;
  logic rd_hit;
  rec_t rd_rec;

  logic s1_valid_q, s1_valid_d;
  logic s1_open_q;
  logic s1_move;
  logic out_valid_q, out_valid_d;
  logic out_hit_q;
  logic out_open_q;
  rec_t out_rec_q;

  assign req.opcode     = req_i.opcode;
  assign req.edge_fall  = req_i.edge_fall;
  assign req.edge_rise  = req_i.edge_rise;
  assign req.data_level = req_i.data_level;
  assign req.time_us    = req_i.time_us;

  assign s1_move     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_move;
  assign accept      = req_i.valid && req_i.ready;
  assign read_acc    = accept && (req.opcode == OP_READ);

  stc_capture #(
    .MAX_BITS (MAX_BITS)
  ) u_capture (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req),
    .push_o     (push),
    .push_rec_o (push_rec),
    .open_o     (open)
  );

  stc_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (read_acc),
    .rd_hit_o   (rd_hit),
    .rd_rec_o   (rd_rec)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (read_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_acc) begin
      s1_open_q <= open;
    end
    if (s1_move) begin
      out_hit_q  <= rd_hit;
      out_open_q <= s1_open_q;
      out_rec_q  <= rd_hit ? rd_rec : '0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.record_valid = out_hit_q;
  assign rsp_o.rec          = out_rec_q;
  assign rsp_o.capture_open = out_open_q;

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q)
    else $error("pending read dropped");

  a_no_accept_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !rsp_o.ready |-> !accept)
    else $error("request taken while pipeline blocked");
endmodule

// ===== test/spi_transaction_capture_checker.sv =====
`timescale 1ns / 1ps
module spi_transaction_capture_checker #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stc_req_if          req_mon,
  stc_rsp_if          rsp_mon,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import stc_pkg::*;

  localparam int unsigned BitCap = (MAX_BITS < WordW) ? MAX_BITS : WordW;

  typedef struct packed {
    logic record_valid;
    rec_t rec;
    logic capture_open;
  } reply_t;

  reply_t           replies_due[$];
  rec_t             ring [QUEUE_DEPTH];
  int unsigned      ring_wr;
  int unsigned      ring_rd;
  int unsigned      ring_fill;
  logic             open_q;
  logic [WordW-1:0] next_id;
  logic [WordW-1:0] cur_start;
  rec_t             cur;

  task automatic track_request(opcode_e op, logic fall, logic rise, logic level,
                               logic [WordW-1:0] t_us);
    reply_t r;
    case (op)
      OP_SELECT: begin
        if (fall) begin
          if (!open_q) begin
            cur            = '0;
            cur.capture_id = next_id;
            next_id        = next_id + 1'b1;
            cur_start      = t_us;
            open_q         = 1'b1;
          end
          if (cur.select_falls != CountMax) cur.select_falls = cur.select_falls + 1'b1;
        end
        if (rise && open_q) begin
          cur.low_duration_us = t_us - cur_start;
          ring[ring_wr]       = cur;
          ring_wr             = (ring_wr + 1) % QUEUE_DEPTH;
          // full ring: newest record replaces the oldest
          if (ring_fill == QUEUE_DEPTH) begin
            ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
          end else begin
            ring_fill++;
          end
          open_q = 1'b0;
        end
      end
      OP_CLOCK: begin
        if (open_q && rise) begin
          if (cur.rx_bit_cnt < BitCap) begin
            cur.rx_bits    = cur.rx_bits | (WordW'(level) << cur.rx_bit_cnt);
            cur.rx_bit_cnt = cur.rx_bit_cnt + 1'b1;
          end
          if (cur.clock_rises != CountMax) cur.clock_rises = cur.clock_rises + 1'b1;
        end
      end
      OP_READ: begin
        r = '0;
        if (ring_fill != 0) begin
          r.record_valid = 1'b1;
          r.rec          = ring[ring_rd];
          ring_rd        = (ring_rd + 1) % QUEUE_DEPTH;
          ring_fill--;
        end
        r.capture_open = open_q;
        replies_due.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  function automatic string field_diff(reply_t e, reply_t a);
    string s;
    s = "";
    if (e.record_valid !== a.record_valid)
      s = {s, $sformatf(" record_valid exp %0b got %0b", e.record_valid, a.record_valid)};
    if (e.rec.capture_id !== a.rec.capture_id)
      s = {s, $sformatf(" capture_id exp %h got %h", e.rec.capture_id, a.rec.capture_id)};
    if (e.rec.low_duration_us !== a.rec.low_duration_us)
      s = {s, $sformatf(" low_duration_us exp %h got %h",
                        e.rec.low_duration_us, a.rec.low_duration_us)};
    if (e.rec.select_falls !== a.rec.select_falls)
      s = {s, $sformatf(" select_falls exp %h got %h", e.rec.select_falls, a.rec.select_falls)};
    if (e.rec.clock_rises !== a.rec.clock_rises)
      s = {s, $sformatf(" clock_rises exp %h got %h", e.rec.clock_rises, a.rec.clock_rises)};
    if (e.rec.rx_bits !== a.rec.rx_bits)
      s = {s, $sformatf(" rx_bits exp %h got %h", e.rec.rx_bits, a.rec.rx_bits)};
    if (e.rec.rx_bit_cnt !== a.rec.rx_bit_cnt)
      s = {s, $sformatf(" rx_bit_cnt exp %0d got %0d",
                        e.rec.rx_bit_cnt, a.rec.rx_bit_cnt)};
    if (e.capture_open !== a.capture_open)
      s = {s, $sformatf(" capture_open exp %0b got %0b", e.capture_open, a.capture_open)};
    return s;
  endfunction

  task automatic flag_mismatch(string what);
    if (errors_o < 10) $display("%0t: read response mismatch:%s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    string  diff;
    if (!rst_ni) begin
      replies_due.delete();
      ring_wr   = 0;
      ring_rd   = 0;
      ring_fill = 0;
      open_q    = 1'b0;
      next_id   = 1;
      cur_start = '0;
      cur       = '0;
    end else begin
      // response first: it always belongs to an older read
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.record_valid = rsp_mon.record_valid;
        got.rec          = rsp_mon.rec;
        got.capture_open = rsp_mon.capture_open;
        if (replies_due.size() == 0) begin
          flag_mismatch($sformatf(" no read pending, got capture_id %h valid %0b",
                                  got.rec.capture_id, got.record_valid));
        end else begin
          want = replies_due.pop_front();
          diff = field_diff(want, got);
          if (diff != "") flag_mismatch(diff);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        track_request(req_mon.opcode, req_mon.edge_fall, req_mon.edge_rise,
                      req_mon.data_level, req_mon.time_us);
      end
    end
    pending_o = replies_due.size();
  end

endmodule

// ===== test/spi_transaction_capture_test.sv =====
`timescale 1ns / 1ps
module spi_transaction_capture_test;
  import stc_pkg::*;

  localparam int unsigned RunLimit    = 1000000;
  localparam int unsigned PhaseItems  = 225;
  localparam int unsigned CapEvents   = 40;
  localparam int unsigned RingFillers = 67;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent = 0;
  logic [31:0] now_us;

  stc_req_if req_if ();
  stc_rsp_if rsp_if ();

  spi_transaction_capture i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  spi_transaction_capture_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req_if),
    .rsp_mon   (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RunLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [31:0] stamp();
    if ($urandom_range(49) == 0) begin
      now_us = $urandom;
    end else begin
      now_us = now_us + $urandom_range(1, 400);
    end
    return now_us;
  endfunction

  task automatic issue_request(opcode_e op, logic fall, logic rise, logic level,
                               logic [31:0] t_us);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid      = 1'b1;
    req_if.opcode     = op;
    req_if.edge_fall  = fall;
    req_if.edge_rise  = rise;
    req_if.data_level = level;
    req_if.time_us    = t_us;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic select_event(logic fall, logic rise);
    issue_request(OP_SELECT, fall, rise, $urandom_range(1), stamp());
    sent++;
  endtask

  task automatic clock_rise();
    issue_request(OP_CLOCK, $urandom_range(1), 1'b1, $urandom_range(1), stamp());
    sent++;
  endtask

  task automatic read_record();
    issue_request(OP_READ, $urandom_range(1), $urandom_range(1), $urandom_range(1), stamp());
    sent++;
  endtask

  task automatic noise_request();
    issue_request(opcode_e'($urandom_range(3)), $urandom_range(1), $urandom_range(1),
                  $urandom_range(1), $urandom);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic run_transfer(int unsigned nbits);
    int unsigned pick;
    select_event(1'b1, $urandom_range(19) == 0);
    for (int unsigned i = 0; i < nbits; i++) begin
      pick = $urandom_range(15);
      if (pick == 0) begin
        issue_request(OP_CLOCK, $urandom_range(1), 1'b0, $urandom_range(1), stamp());
      end else if (pick == 1) begin
        select_event(1'b1, 1'b0);
      end else if (pick == 2) begin
        read_record();
      end
      clock_rise();
    end
    // now and then the select never comes back up
    if ($urandom_range(14) != 0) select_event($urandom_range(3) == 0, 1'b1);
  endtask

  initial begin
    int unsigned pick;
    int unsigned goal;
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 55, 0, 34};
    stall_tab = '{0, 0, 55, 34};
    now_us = $urandom;
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_NONE;
    req_if.edge_fall  = 1'b0;
    req_if.edge_rise  = 1'b0;
    req_if.data_level = 1'b0;
    req_if.time_us    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    issue_request(OP_READ,   1'b0, 1'b0, 1'b0, 32'h0000_0000);
    issue_request(OP_NONE,   1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    issue_request(OP_SELECT, 1'b0, 1'b1, 1'b1, 32'h0000_0100);
    issue_request(OP_CLOCK,  1'b1, 1'b1, 1'b1, 32'h0000_0200);
    issue_request(OP_SELECT, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF0);
    issue_request(OP_READ,   1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    issue_request(OP_CLOCK,  1'b1, 1'b0, 1'b1, 32'h0000_0001);
    issue_request(OP_CLOCK,  1'b0, 1'b1, 1'b1, 32'h0000_0002);
    issue_request(OP_CLOCK,  1'b0, 1'b1, 1'b0, 32'h0000_0003);
    issue_request(OP_CLOCK,  1'b1, 1'b1, 1'b1, 32'h0000_0004);
    issue_request(OP_SELECT, 1'b1, 1'b0, 1'b1, 32'h0000_0005);
    issue_request(OP_SELECT, 1'b0, 1'b0, 1'b1, 32'h0000_0006);
    issue_request(OP_SELECT, 1'b0, 1'b1, 1'b0, 32'h0000_0010);
    issue_request(OP_SELECT, 1'b1, 1'b1, 1'b0, 32'h5555_AAAA);
    issue_request(OP_SELECT, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
    issue_request(OP_SELECT, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    issue_request(OP_CLOCK,  1'b0, 1'b1, 1'b1, 32'hAAAA_5555);
    repeat (4) issue_request(OP_READ, 1'b0, 1'b0, 1'b0, 32'h1234_5678);

    // bit store runs past its cap
    select_event(1'b1, 1'b0);
    for (int unsigned i = 0; i < CapEvents; i++) begin
      issue_request(OP_CLOCK, 1'b0, 1'b1, $urandom_range(1), stamp());
      issue_request(OP_SELECT, 1'b1, 1'b0, 1'b0, stamp());
    end
    select_event(1'b0, 1'b1);
    read_record();

    // overrun the ring, then empty it past the bottom
    for (int unsigned i = 0; i < RingFillers; i++) begin
      select_event(1'b1, 1'b0);
      repeat ($urandom_range(3)) clock_rise();
      select_event(1'b0, 1'b1);
    end
    repeat (RingFillers + 3) read_record();
    wait_drained();

    sent = 0;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      goal      = (p + 1) * PhaseItems;
      while (sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          run_transfer($urandom_range(40));
          repeat ($urandom_range(2)) read_record();
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 5)) read_record();
        end else begin
          noise_request();
        end
      end
      wait_drained();
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
